### hdl/sbq_pkg.sv
package sbq_pkg;

    // Fixed field widths
    localparam int COEF_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int THR_BITS   = 20;
    localparam int BW_BITS    = 11;
    localparam int DVD_BITS   = COEF_BITS + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND_IS_DC      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HAS_PARENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ORIENT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_FACTOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NBHD_THRESHOLD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH      = 3'd6;

    // Orientation codes
    localparam logic [1:0] ORIENT_HORIZ = 2'd1;
    localparam logic [1:0] ORIENT_VERT  = 2'd2;

    // Magnitude contexts
    localparam logic [2:0] MCTX_ZP_QUIET = 3'd0;
    localparam logic [2:0] MCTX_ZP_BUSY  = 3'd1;
    localparam logic [2:0] MCTX_P_QUIET  = 3'd2;
    localparam logic [2:0] MCTX_P_LOW    = 3'd3;
    localparam logic [2:0] MCTX_P_HIGH   = 3'd4;

    // Sign contexts
    localparam logic [1:0] SCTX_ZERO = 2'd0;
    localparam logic [1:0] SCTX_POS  = 2'd1;
    localparam logic [1:0] SCTX_NEG  = 2'd2;

    // Prediction source
    localparam logic [1:0] PRED_NONE = 2'd0;
    localparam logic [1:0] PRED_UP   = 2'd1;
    localparam logic [1:0] PRED_LEFT = 2'd2;
    localparam logic [1:0] PRED_AVG  = 2'd3;

    // x/3 = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 2^17
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

endpackage

### hdl/sbq_in_if.sv
interface sbq_in_if;
    import sbq_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;
    logic signed [COEF_BITS-1:0] parent_coefficient;
    logic                        last_of_band;

    modport source (output valid, coefficient, parent_coefficient, last_of_band,
                    input ready);
    modport sink   (input valid, coefficient, parent_coefficient, last_of_band,
                    output ready);
endinterface

### hdl/sbq_out_if.sv
interface sbq_out_if;
    import sbq_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [COEF_BITS-1:0]        magnitude;
    logic                        sign_positive;
    logic [2:0]                  magnitude_context;
    logic                        follow_context;
    logic [1:0]                  sign_ctx;
    logic signed [COEF_BITS-1:0] reconstructed;
    logic                        band_all_zero;
    logic                        is_last;

    modport source (output valid, magnitude, sign_positive, magnitude_context,
                    follow_context, sign_ctx, reconstructed, band_all_zero,
                    is_last, input ready);
    modport sink   (input valid, magnitude, sign_positive, magnitude_context,
                    follow_context, sign_ctx, reconstructed, band_all_zero,
                    is_last, output ready);
endinterface

### hdl/sbq_cfg_if.sv
interface sbq_cfg_if;
    import sbq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/sbq_div.sv
module sbq_div
    import sbq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DVD_BITS-1:0]  dividend,
    input  logic [COEF_BITS-1:0] divisor,
    output logic                 done,
    output logic [DVD_BITS-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_BITS + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;
    logic [DVD_BITS-1:0]  dvd_reg;
    logic [COEF_BITS-1:0] rem_reg;
    logic [COEF_BITS-1:0] div_reg;
    logic [COEF_BITS:0]   rem_sh;
    logic                 fits;

    // one restoring step per cycle, quotient bits shift into the dividend
    assign rem_sh = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CNT_W'(DVD_BITS);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DVD_BITS-2:0], fits};
            rem_reg <= fits ? COEF_BITS'(rem_sh - {1'b0, div_reg})
                            : rem_sh[COEF_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### hdl/subband_coefficient_quantizer_core.sv
// Subband coefficient quantizer with entropy-coder context selection.
//
// Channels: item (sink) carries one coefficient, its parent coefficient and
// the last-of-band flag; result (source) carries magnitude, sign, contexts,
// reconstruction and band flags; cfg (sink) writes one register per transfer
// and is always ready. Write cfg only while the block is idle.
//
// One item is in work at a time. An item whose dead-zone numerator is
// negative passes through the states PRED, DIV3, RES, MUL and FIN before
// its result is loaded; any other item also waits in DIV for the
// bit-serial quant-factor divider (17 steps). The row store is a
// single-port memory read at item transfer and written when the result is loaded.
//
// Reset restores the register defaults and the band state; the row store
// is not cleared, each entry is written on the first row before use.
// A stalled result sits in the output register; the block takes the next
// item meanwhile and waits with its finished result until the register
// frees up.
module subband_coefficient_quantizer_core
    import sbq_pkg::*;
#(
    parameter int MAX_BAND_WIDTH = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    sbq_in_if.sink   item,
    sbq_out_if.source result,
    sbq_cfg_if.sink  cfg
);

    localparam int CW   = $clog2(MAX_BAND_WIDTH);
    localparam int CMPW = CW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DIV3 = 3'd2;
    localparam logic [2:0] S_RES  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // configuration registers
    logic                  dc_reg;
    logic                  parent_reg;
    logic [1:0]            orient_reg;
    logic [COEF_BITS-1:0]  qf_reg;
    logic [COEF_BITS-1:0]  qo_reg;
    logic [THR_BITS-1:0]   thr_reg;
    logic [BW_BITS-1:0]    bw_reg;

    // band state
    logic [2:0]                  state_reg;
    logic signed [COEF_BITS-1:0] left_reg;
    logic signed [COEF_BITS-1:0] upleft_reg;
    logic [CW-1:0]               col_reg;
    logic                        first_row_reg;
    logic                        all_zero_reg;

    // per-item work registers
    logic signed [COEF_BITS-1:0] coef_reg;
    logic signed [COEF_BITS-1:0] parent_coef_reg;
    logic                        last_reg;
    logic signed [COEF_BITS-1:0] up_reg;
    logic [16:0]                 sabs_reg;
    logic                        sneg_reg;
    logic [1:0]                  pmode_reg;
    logic [2:0]                  mctx_reg;
    logic                        fctx_reg;
    logic [1:0]                  sctx_reg;
    logic [32:0]                 p3_reg;
    logic signed [COEF_BITS-1:0] pred_reg;
    logic                        sign_reg;
    logic [COEF_BITS-1:0]        q_reg;
    logic [2*COEF_BITS-1:0]      mprod_reg;

    // row store
    logic signed [COEF_BITS-1:0] row_mem [MAX_BAND_WIDTH];
    logic signed [COEF_BITS-1:0] rd_data_reg;

    // output register
    logic                        out_valid_reg;
    logic [COEF_BITS-1:0]        o_mag_reg;
    logic                        o_sign_reg;
    logic [2:0]                  o_mctx_reg;
    logic                        o_fctx_reg;
    logic [1:0]                  o_sctx_reg;
    logic signed [COEF_BITS-1:0] o_rec_reg;
    logic                        o_allz_reg;
    logic                        o_last_reg;

    logic                 in_fire;
    logic                 fin_fire;
    logic                 has_left;
    logic                 has_up;
    logic signed [COEF_BITS-1:0] up_val;
    logic signed [17:0]   sum3;
    logic [16:0]          abs_up;
    logic [16:0]          abs_left;
    logic [16:0]          abs_ul;
    logic [17:0]          nsum;
    logic                 parent_is_zero;
    logic signed [COEF_BITS-1:0] prev;
    logic [COEF_BITS-1:0] qf_eff;
    logic [15:0]          quot3;
    logic signed [16:0]   avg_s;
    logic signed [COEF_BITS-1:0] pred_c;
    logic signed [16:0]   res;
    logic [16:0]          res_abs;
    logic signed [18:0]   num;
    logic                 div_start;
    logic                 div_done;
    logic [DVD_BITS-1:0]  div_q;
    logic [COEF_BITS-1:0] amt;
    logic [COEF_BITS-1:0] rec;
    logic [CMPW-1:0]      width_eff;
    logic [CMPW-1:0]      col_inc;

    assign in_fire  = item.valid && item.ready;
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || result.ready);
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign qf_eff = (qf_reg == '0) ? COEF_BITS'(1) : qf_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg     <= 1'b1;
            parent_reg <= 1'b0;
            orient_reg <= 2'd0;
            qf_reg     <= COEF_BITS'(4);
            qo_reg     <= COEF_BITS'(1);
            thr_reg    <= '0;
            bw_reg     <= BW_BITS'(1024);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_BAND_IS_DC:      dc_reg     <= cfg.data[0];
                REG_BAND_HAS_PARENT: parent_reg <= cfg.data[0];
                REG_BAND_ORIENT:     orient_reg <= cfg.data[1:0];
                REG_QUANT_FACTOR:    qf_reg     <= cfg.data[COEF_BITS-1:0];
                REG_QUANT_OFFSET:    qo_reg     <= cfg.data[COEF_BITS-1:0];
                REG_NBHD_THRESHOLD:  thr_reg    <= cfg.data[THR_BITS-1:0];
                REG_BAND_WIDTH:      bw_reg     <= cfg.data[BW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // row store: read at item transfer, write at result load
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= row_mem[col_reg];
        if (fin_fire)
            row_mem[col_reg] <= rec;
    end

    // neighbourhood, contexts and prediction source
    assign has_left = (col_reg != '0);
    assign has_up   = !first_row_reg;
    assign up_val   = has_up ? rd_data_reg : '0;
    assign sum3     = 18'(left_reg) + 18'(up_val) + 18'(upleft_reg);
    assign abs_up   = has_up ? 17'(up_val < 0 ? -17'(up_val) : 17'(up_val)) : '0;
    assign abs_left = has_left ? 17'(left_reg < 0 ? -17'(left_reg) : 17'(left_reg)) : '0;
    assign abs_ul   = (has_up && has_left)
                      ? 17'(upleft_reg < 0 ? -17'(upleft_reg) : 17'(upleft_reg)) : '0;
    assign nsum     = 18'(abs_up) + 18'(abs_left) + 18'(abs_ul);
    assign parent_is_zero = parent_reg ? (parent_coef_reg == '0) : !dc_reg;

    always_comb
    begin
        prev = '0;
        if (orient_reg == ORIENT_HORIZ && has_left)
            prev = left_reg;
        else if (orient_reg == ORIENT_VERT && has_up)
            prev = up_val;
    end

    // prediction and dead-zone numerator
    assign quot3 = p3_reg[RECIP3_SHIFT +: 16];
    assign avg_s = sneg_reg ? -17'(quot3) : 17'(quot3);

    always_comb
    begin
        case (pmode_reg)
            PRED_UP:   pred_c = up_reg;
            PRED_LEFT: pred_c = left_reg;
            PRED_AVG:  pred_c = avg_s[COEF_BITS-1:0];
            default:   pred_c = '0;
        endcase
    end

    assign res       = 17'(coef_reg) - 17'(pred_c);
    assign res_abs   = res[16] ? 17'(-res) : 17'(res);
    assign num       = 19'(res_abs) + 19'(qf_eff >> 1) - 19'(qo_reg);
    assign div_start = (state_reg == S_RES) && !num[18];

    sbq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num[DVD_BITS-1:0]),
        .divisor  (qf_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // reconstruction
    assign amt = qo_reg + mprod_reg[COEF_BITS-1:0];
    assign rec = (q_reg == '0) ? COEF_BITS'(pred_reg)
               : (sign_reg ? COEF_BITS'(pred_reg) + amt : COEF_BITS'(pred_reg) - amt);

    // column advance
    always_comb
    begin
        if (bw_reg == '0)
            width_eff = CMPW'(1);
        else if (CMPW'(bw_reg) > CMPW'(MAX_BAND_WIDTH))
            width_eff = CMPW'(MAX_BAND_WIDTH);
        else
            width_eff = CMPW'(bw_reg);
    end
    assign col_inc = CMPW'(col_reg) + CMPW'(1);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            upleft_reg    <= '0;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            all_zero_reg  <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_fire) state_reg <= S_PRED;
                S_PRED: state_reg <= S_DIV3;
                S_DIV3: state_reg <= S_RES;
                S_RES:  state_reg <= num[18] ? S_MUL : S_DIV;
                S_DIV:  if (div_done) state_reg <= S_MUL;
                S_MUL:  state_reg <= S_FIN;
                S_FIN:
                begin
                    if (fin_fire)
                    begin
                        state_reg  <= S_IDLE;
                        left_reg   <= rec;
                        upleft_reg <= up_reg;
                        if (col_inc >= width_eff)
                        begin
                            col_reg       <= '0;
                            first_row_reg <= 1'b0;
                        end
                        else
                            col_reg <= col_inc[CW-1:0];
                        if (q_reg != '0)
                            all_zero_reg <= 1'b0;
                        if (last_reg)
                        begin
                            left_reg      <= '0;
                            upleft_reg    <= '0;
                            col_reg       <= '0;
                            first_row_reg <= 1'b1;
                            all_zero_reg  <= 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            coef_reg        <= item.coefficient;
            parent_coef_reg <= item.parent_coefficient;
            last_reg        <= item.last_of_band;
        end
        if (state_reg == S_PRED)
        begin
            up_reg   <= up_val;
            sneg_reg <= sum3[17];
            sabs_reg <= sum3[17] ? 17'(-sum3) : sum3[16:0];
            if (!dc_reg)
                pmode_reg <= PRED_NONE;
            else if (has_up && has_left)
                pmode_reg <= PRED_AVG;
            else if (has_up)
                pmode_reg <= PRED_UP;
            else if (has_left)
                pmode_reg <= PRED_LEFT;
            else
                pmode_reg <= PRED_NONE;
            if (parent_is_zero)
            begin
                mctx_reg <= (nsum == '0) ? MCTX_ZP_QUIET : MCTX_ZP_BUSY;
                fctx_reg <= 1'b0;
            end
            else
            begin
                if (nsum == '0)
                    mctx_reg <= MCTX_P_QUIET;
                else if (20'(nsum) <= thr_reg)
                    mctx_reg <= MCTX_P_LOW;
                else
                    mctx_reg <= MCTX_P_HIGH;
                fctx_reg <= 1'b1;
            end
            sctx_reg <= (prev > 0) ? SCTX_POS : ((prev < 0) ? SCTX_NEG : SCTX_ZERO);
        end
        if (state_reg == S_DIV3)
            p3_reg <= 33'(sabs_reg) * 33'(RECIP3);
        if (state_reg == S_RES)
        begin
            pred_reg <= pred_c;
            sign_reg <= !res[16];
            if (num[18])
                q_reg <= '0;
        end
        if (state_reg == S_DIV && div_done)
            q_reg <= div_q[DVD_BITS-1] ? '1 : div_q[COEF_BITS-1:0];
        if (state_reg == S_MUL)
            mprod_reg <= qf_eff * q_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            o_mag_reg  <= q_reg;
            o_sign_reg <= sign_reg;
            o_mctx_reg <= mctx_reg;
            o_fctx_reg <= fctx_reg;
            o_sctx_reg <= sctx_reg;
            o_rec_reg  <= rec;
            o_allz_reg <= last_reg && all_zero_reg && (q_reg == '0);
            o_last_reg <= last_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.magnitude         = o_mag_reg;
    assign result.sign_positive     = o_sign_reg;
    assign result.magnitude_context = o_mctx_reg;
    assign result.follow_context    = o_fctx_reg;
    assign result.sign_ctx          = o_sctx_reg;
    assign result.reconstructed     = o_rec_reg;
    assign result.band_all_zero     = o_allz_reg;
    assign result.is_last           = o_last_reg;

    // checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_PRED)
        else $error("item taken outside idle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(col_reg) < CMPW'(MAX_BAND_WIDTH))
        else $error("column counter out of range");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load lost");

endmodule
